// ----- rtl/ccsb_pkg.sv -----
// ----------------------------------------------------------------------------
// ccsb_pkg: shared types, constants and helpers for the character-class
// bitmap builder.
// ----------------------------------------------------------------------------
`default_nettype none

package ccsb_pkg;

  localparam int unsigned SetBits   = 256;
  localparam int unsigned WordBits  = 64;
  localparam int unsigned NumWords  = SetBits / WordBits;
  localparam int unsigned WordIdxW  = $clog2(NumWords);

  localparam logic [7:0] CH_ESC  = 8'h7E;
  localparam logic [7:0] CH_STAR = 8'h2A;
  localparam logic [7:0] CH_DASH = 8'h2D;

  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_END  = 1'b1;

  localparam logic [WordIdxW-1:0] LAST_IDX = WordIdxW'(NumWords - 1);

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_ESC_L  = 3'd1,
    PH_HEX_L  = 3'd2,
    PH_HAVE_L = 3'd3,
    PH_RANGE  = 3'd4,
    PH_ESC_R  = 3'd5,
    PH_HEX_R  = 3'd6
  } phase_t;

  typedef logic [WordBits-1:0] word_t;
  typedef logic [SetBits-1:0]  set_t;

  function automatic logic is_hex(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
           (c >= 8'h41 && c <= 8'h46);
  endfunction

  function automatic logic [3:0] nibble(input logic [7:0] c);
    logic [7:0] v;
    v = 8'h00;
    if (c >= 8'h61 && c <= 8'h66) v = c - 8'h57;
    else if (c >= 8'h41 && c <= 8'h46) v = c - 8'h37;
    else if (c >= 8'h30 && c <= 8'h39) v = c - 8'h30;
    return v[3:0];
  endfunction

  // One comparator pair per code; an inverted range gives an empty mask.
  function automatic set_t range_mask(input logic en, input logic [7:0] lo,
                                      input logic [7:0] hi);
    set_t m;
    m = '0;
    for (int i = 0; i < SetBits; i++) begin
      m[i] = en && (lo <= 8'(i)) && (8'(i) <= hi);
    end
    return m;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/char_class_spec_to_bitmap.sv -----
// ----------------------------------------------------------------------------
// char_class_spec_to_bitmap: character-class bitmap builder
// Parses a character-class spec one byte per transaction into a 256-bit set
// and emits the set as four 64-bit words on an end transaction.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid/in_ready) carries in_kind and in_spec_byte.
//   A spec byte transaction (kind 0) updates the parser and the set in the
//   cycle it is accepted; one spec byte is taken every cycle.
//   An end transaction (kind 1) closes any pending escape or range, copies
//   the finished set into a four-word output buffer and clears the parser,
//   so bytes of the next spec are accepted right away.
//   The output channel (out_valid/out_ready) then shows words 0..3, one per
//   cycle while out_ready is high, the first in the cycle after the end
//   transaction; out_last_word marks word 3.
//   The output buffer holds one set, so a second end transaction waits
//   (in_ready low while in_kind is 1) until the last word of the previous
//   set has been taken; a stalled receiver therefore stalls only end
//   transactions, never spec bytes.
//   Reset (rst_n low, synchronous) empties the set, returns the parser to
//   idle and drops out_valid.
// ----------------------------------------------------------------------------
`default_nettype none

module char_class_spec_to_bitmap
  import ccsb_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic                in_kind,
  input  wire logic [7:0]          in_spec_byte,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [WordBits-1:0]      out_set_word,
  output logic [WordIdxW-1:0]      out_word_index,
  output logic                     out_last_word
);

  // Parser and set state.
  phase_t      phase_r, phase_nxt;
  logic [7:0]  held_r, held_nxt;
  logic [7:0]  range_low_r, range_low_nxt;
  logic [1:0]  seen_r, seen_nxt;
  set_t        set_r, set_nxt;

  // Output buffer: word 0 of the array is always the word on the port.
  word_t                 snap_r [NumWords];
  logic                  busy_r;
  logic [WordIdxW-1:0]   idx_r;

  logic   in_fire, out_fire, byte_fire, end_fire;
  logic   add_en;
  logic [7:0] add_lo, add_hi;
  logic   fin_en;
  logic [7:0] fin_lo, fin_hi;
  logic   star;
  set_t   final_set;

  assign in_ready  = (in_kind == KIND_BYTE) || !busy_r;
  assign in_fire   = in_valid && in_ready;
  assign byte_fire = in_fire && (in_kind == KIND_BYTE);
  assign end_fire  = in_fire && (in_kind == KIND_END);
  assign out_fire  = busy_r && out_ready;

  // Per-byte parser step. Each byte adds at most one range to the set.
  always_comb begin
    phase_nxt     = phase_r;
    held_nxt      = held_r;
    range_low_nxt = range_low_r;
    add_en        = 1'b0;
    add_lo        = held_r;
    add_hi        = held_r;
    unique case (phase_r)
      PH_IDLE: begin
        if (in_spec_byte == CH_ESC) begin
          phase_nxt = PH_ESC_L;
        end else begin
          held_nxt  = in_spec_byte;
          phase_nxt = PH_HAVE_L;
        end
      end
      PH_ESC_L: begin
        if (is_hex(in_spec_byte)) begin
          held_nxt  = {4'h0, nibble(in_spec_byte)};
          phase_nxt = PH_HEX_L;
        end else begin
          held_nxt  = in_spec_byte;
          phase_nxt = PH_HAVE_L;
        end
      end
      PH_HEX_L: begin
        held_nxt  = {held_r[3:0], nibble(in_spec_byte)};
        phase_nxt = PH_HAVE_L;
      end
      PH_HAVE_L: begin
        if (in_spec_byte == CH_DASH) begin
          range_low_nxt = held_r;
          phase_nxt     = PH_RANGE;
        end else begin
          // The held code is a single member; the byte starts a new atom.
          add_en = 1'b1;
          if (in_spec_byte == CH_ESC) begin
            phase_nxt = PH_ESC_L;
          end else begin
            held_nxt  = in_spec_byte;
            phase_nxt = PH_HAVE_L;
          end
        end
      end
      PH_RANGE: begin
        if (in_spec_byte == CH_ESC) begin
          phase_nxt = PH_ESC_R;
        end else begin
          add_en    = 1'b1;
          add_lo    = range_low_r;
          add_hi    = in_spec_byte;
          phase_nxt = PH_IDLE;
        end
      end
      PH_ESC_R: begin
        if (is_hex(in_spec_byte)) begin
          held_nxt  = {4'h0, nibble(in_spec_byte)};
          phase_nxt = PH_HEX_R;
        end else begin
          add_en    = 1'b1;
          add_lo    = range_low_r;
          add_hi    = in_spec_byte;
          phase_nxt = PH_IDLE;
        end
      end
      PH_HEX_R: begin
        add_en    = 1'b1;
        add_lo    = range_low_r;
        add_hi    = {held_r[3:0], nibble(in_spec_byte)};
        phase_nxt = PH_IDLE;
      end
      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase
  end

  // Closing step at an end transaction: finish whatever atom is pending.
  always_comb begin
    fin_en = 1'b1;
    fin_lo = held_r;
    fin_hi = held_r;
    unique case (phase_r)
      PH_ESC_L: begin
        fin_lo = 8'h00;
        fin_hi = 8'h00;
      end
      PH_HEX_L, PH_HAVE_L: begin
        fin_lo = held_r;
        fin_hi = held_r;
      end
      PH_RANGE, PH_ESC_R: begin
        fin_lo = range_low_r;
        fin_hi = 8'h00;
      end
      PH_HEX_R: begin
        fin_lo = range_low_r;
        fin_hi = held_r;
      end
      default: begin
        fin_en = 1'b0;
      end
    endcase
  end

  // A spec of exactly one '*' byte fills the whole set.
  assign star = (seen_r == 2'd1) && (phase_r == PH_HAVE_L) && (held_r == CH_STAR);

  assign final_set = star ? '1 : (set_r | range_mask(fin_en, fin_lo, fin_hi));

  always_comb begin
    seen_nxt = seen_r;
    set_nxt  = set_r;
    if (byte_fire) begin
      set_nxt = set_r | range_mask(add_en, add_lo, add_hi);
      if (seen_r != 2'd2) seen_nxt = seen_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || end_fire) begin
      phase_r     <= PH_IDLE;
      held_r      <= 8'h00;
      range_low_r <= 8'h00;
      seen_r      <= 2'd0;
      set_r       <= '0;
    end else if (byte_fire) begin
      phase_r     <= phase_nxt;
      held_r      <= held_nxt;
      range_low_r <= range_low_nxt;
      seen_r      <= seen_nxt;
      set_r       <= set_nxt;
    end
  end

  // Output buffer control: load on an end transaction, shift on each take.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
    end else if (end_fire) begin
      busy_r <= 1'b1;
      idx_r  <= '0;
    end else if (out_fire) begin
      if (idx_r == LAST_IDX) busy_r <= 1'b0;
      idx_r <= idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (end_fire) begin
      for (int k = 0; k < NumWords; k++) begin
        snap_r[k] <= final_set[k*WordBits +: WordBits];
      end
    end else if (out_fire) begin
      for (int k = 0; k < NumWords - 1; k++) begin
        snap_r[k] <= snap_r[k+1];
      end
    end
  end

  assign out_valid      = busy_r;
  assign out_set_word   = snap_r[0];
  assign out_word_index = idx_r;
  assign out_last_word  = (idx_r == LAST_IDX);

endmodule

`default_nettype wire

// ----- rtl/ccsb_checker.sv -----
// ----------------------------------------------------------------------------
// ccsb_checker: port-level checks for the character-class bitmap builder
// Watches the result channel for word ordering and stall behavior, and spec bytes for readiness.
// ----------------------------------------------------------------------------
`default_nettype none

module ccsb_checker
  import ccsb_pkg::*;
(
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_valid,
  input wire logic                in_ready,
  input wire logic                in_kind,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire logic [WordBits-1:0] out_set_word,
  input wire logic [WordIdxW-1:0] out_word_index,
  input wire logic                out_last_word
);

  // Reset drops the result channel.
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  // A set always starts with word 0.
  a_first_word: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> (out_word_index == '0))
    else $error("set did not start at word 0");

  // Words of one set follow each other without a gap.
  a_next_word: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !out_last_word) |=>
      (out_valid && out_word_index == $past(out_word_index) + 1'b1))
    else $error("word sequence broken");

  // A stalled word holds its payload.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_set_word) && $stable(out_word_index)))
    else $error("stalled word changed");

  // Spec bytes are never held off.
  a_byte_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_kind == KIND_BYTE) |-> in_ready)
    else $error("spec byte stalled");

endmodule

bind char_class_spec_to_bitmap ccsb_checker u_ccsb_checker (.*);

`default_nettype wire

// ----- test/char_class_spec_to_bitmap_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// char_class_spec_to_bitmap_test: self-checking bench for the bitmap builder
// Feeds character-class specs byte by byte, follows every accepted
// transaction with a parser and set of its own, and compares each of the
// four words of every emitted set against it in order.
// ----------------------------------------------------------------------------

module char_class_spec_to_bitmap_test
  import ccsb_pkg::*;
();

  // Run length and pressure knobs.
  localparam int TotalItems = 370;
  localparam int TailStart  = 330;
  localparam int DrainAt    = 200;
  localparam int HoldCycles = 250;
  localparam int CycleLimit = 300000;

  // One word of an emitted set, as it appears on the result channel.
  typedef struct packed {
    word_t               bits;
    logic [WordIdxW-1:0] idx;
    logic                last;
  } quarter_t;

  // --------------------------------------------------------------------------
  // Set tracker: mirrors the spec parser and the 256-bit membership set, and
  // keeps the words of every closed set until they come out of the block.
  // --------------------------------------------------------------------------
  class member_set_board;
    set_t       members;
    phase_t     phase;
    logic [7:0] held;
    logic [7:0] span_low;
    logic [1:0] seen;
    quarter_t   pending_words[$];
    int         errors;
    int         words_checked;
    int         sets_closed;

    function new();
      clear_spec();
      errors        = 0;
      words_checked = 0;
      sets_closed   = 0;
    endfunction

    function void clear_spec();
      members  = '0;
      phase    = PH_IDLE;
      held     = 8'h00;
      span_low = 8'h00;
      seen     = 2'd0;
    endfunction

    function bit hex_digit_ok(logic [7:0] c);
      return (c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]});
    endfunction

    // Any byte that is not a hex digit reads as zero.
    function logic [3:0] hex_value(logic [7:0] c);
      logic [7:0] v;
      v = 8'h00;
      if (c >= 8'h30 && c <= 8'h39) v = c - 8'h30;
      else if (c >= 8'h41 && c <= 8'h46) v = c - 8'h41 + 8'd10;
      else if (c >= 8'h61 && c <= 8'h66) v = c - 8'h61 + 8'd10;
      return v[3:0];
    endfunction

    // Inclusive range; an inverted range adds nothing.
    function void add_span(logic [7:0] a, logic [7:0] b);
      for (int i = 0; i < SetBits; i++) begin
        if (int'(a) <= i && i <= int'(b)) members[i] = 1'b1;
      end
    endfunction

    function void open_atom(logic [7:0] b);
      if (b == CH_ESC) begin
        phase = PH_ESC_L;
      end else begin
        held  = b;
        phase = PH_HAVE_L;
      end
    endfunction

    function void take_spec_byte(logic [7:0] b);
      case (phase)
        PH_IDLE: begin
          open_atom(b);
        end
        PH_ESC_L: begin
          if (hex_digit_ok(b)) begin
            held  = {4'h0, hex_value(b)};
            phase = PH_HEX_L;
          end else begin
            held  = b;
            phase = PH_HAVE_L;
          end
        end
        PH_HEX_L: begin
          held  = {held[3:0], hex_value(b)};
          phase = PH_HAVE_L;
        end
        PH_HAVE_L: begin
          if (b == CH_DASH) begin
            span_low = held;
            phase    = PH_RANGE;
          end else begin
            add_span(held, held);
            open_atom(b);
          end
        end
        PH_RANGE: begin
          if (b == CH_ESC) begin
            phase = PH_ESC_R;
          end else begin
            add_span(span_low, b);
            phase = PH_IDLE;
          end
        end
        PH_ESC_R: begin
          if (hex_digit_ok(b)) begin
            held  = {4'h0, hex_value(b)};
            phase = PH_HEX_R;
          end else begin
            add_span(span_low, b);
            phase = PH_IDLE;
          end
        end
        PH_HEX_R: begin
          add_span(span_low, {held[3:0], hex_value(b)});
          phase = PH_IDLE;
        end
        default: begin
          phase = PH_IDLE;
        end
      endcase
      if (seen < 2'd2) seen++;
    endfunction

    // Closes whatever is pending, queues the four words and starts afresh.
    function void close_spec();
      bit       star;
      quarter_t q;
      star = (seen == 2'd1) && (phase == PH_HAVE_L) && (held == CH_STAR);
      case (phase)
        PH_ESC_L:            add_span(8'h00, 8'h00);
        PH_HEX_L, PH_HAVE_L: add_span(held, held);
        PH_RANGE, PH_ESC_R:  add_span(span_low, 8'h00);
        PH_HEX_R:            add_span(span_low, held);
        default: ;
      endcase
      if (star) members = '1;
      for (int k = 0; k < NumWords; k++) begin
        q.bits = members[k*WordBits +: WordBits];
        q.idx  = WordIdxW'(k);
        q.last = (q.idx == LAST_IDX);
        pending_words.push_back(q);
      end
      sets_closed++;
      clear_spec();
    endfunction

    function void note_transaction(logic kind, logic [7:0] b);
      if (kind == KIND_END) close_spec();
      else take_spec_byte(b);
    endfunction

    function void check_word(word_t bits, logic [WordIdxW-1:0] idx, logic last);
      quarter_t want;
      if (pending_words.size() == 0) begin
        errors++;
        if (errors <= 10) begin
          $display("Unexpected word: set_word=%h index=%0d last=%0d", bits, idx, last);
        end
        return;
      end
      want = pending_words.pop_front();
      words_checked++;
      if (want.bits !== bits || want.idx !== idx || want.last !== last) begin
        errors++;
        if (errors <= 10) begin
          $display("Mismatch: expected set_word=%h index=%0d last=%0d",
                   want.bits, want.idx, want.last);
          $display("          actual   set_word=%h index=%0d last=%0d",
                   bits, idx, last);
        end
      end
    endfunction

    function int pending();
      return pending_words.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, DUT and shared control flags.
  // --------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic in_kind;
  logic [7:0] in_spec_byte;
  logic out_valid;
  logic out_ready;
  logic [WordBits-1:0] out_set_word;
  logic [WordIdxW-1:0] out_word_index;
  logic out_last_word;

  member_set_board board;
  int items_sent = 0;
  int cycles     = 0;
  // Set by the sender to ask the receiver for one long hold-off.
  bit hold_receiver = 1'b0;
  // Final stretch of the run: both sides run without idle bursts.
  bit tail_phase = 1'b0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  char_class_spec_to_bitmap u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_kind       (in_kind),
    .in_spec_byte  (in_spec_byte),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_set_word  (out_set_word),
    .out_word_index(out_word_index),
    .out_last_word (out_last_word)
  );

  // --------------------------------------------------------------------------
  // Monitor: all sampling happens at the rising edge, and every accepted
  // transaction on either channel goes to the set tracker. The cycle
  // counter doubles as the watchdog.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("Timeout after %0d cycles with %0d words outstanding", cycles,
               board.pending());
      $display("CHECKS FAILED");
      $finish;
    end else if (rst_n) begin
      if (in_valid && in_ready) board.note_transaction(in_kind, in_spec_byte);
      if (out_valid && out_ready) begin
        board.check_word(out_set_word, out_word_index, out_last_word);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: out_ready toggles in random bursts of low and high, so stalls
  // land on every word of a set. On request it holds off for a long
  // stretch, counted here, which fills the output buffer and makes the
  // block refuse the next end transaction. In the tail it simply stays
  // ready.
  // --------------------------------------------------------------------------
  initial begin
    int  burst;
    bit  level;
    out_ready = 1'b0;
    forever begin
      if (tail_phase) begin
        @(negedge clk);
        out_ready = 1'b1;
      end else if (hold_receiver) begin
        hold_receiver = 1'b0;
        repeat (HoldCycles) begin
          @(negedge clk);
          out_ready = 1'b0;
        end
      end else begin
        level = ($urandom_range(0, 2) != 0);
        burst = level ? $urandom_range(1, 40) : $urandom_range(1, 11);
        repeat (burst) begin
          @(negedge clk);
          out_ready = level;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sender tasks. Inputs change only at the falling edge. A transaction is
  // offered with valid held high until in_ready is seen at a rising edge;
  // valid is not lowered afterwards unless an idle burst follows, so
  // back-to-back transactions keep valid high throughout.
  // --------------------------------------------------------------------------
  task automatic send_item(input logic kind, input logic [7:0] b);
    int gap;
    if (!tail_phase && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 11);
      repeat (gap) begin
        @(negedge clk);
        in_valid     = 1'b0;
        in_kind      = 1'($urandom_range(0, 1));
        in_spec_byte = 8'($urandom_range(0, 255));
      end
    end
    @(negedge clk);
    in_valid     = 1'b1;
    in_kind      = kind;
    in_spec_byte = b;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  task automatic send_byte(input logic [7:0] b);
    send_item(KIND_BYTE, b);
  endtask

  // The byte field of an end transaction is ignored, so it is random.
  task automatic send_end();
    send_item(KIND_END, 8'($urandom_range(0, 255)));
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    bit upper;
    upper = 1'($urandom_range(0, 1));
    if (n < 4'd10) return 8'h30 + 8'(n);
    return (upper ? 8'h41 : 8'h61) + 8'(n) - 8'd10;
  endfunction

  function automatic logic [7:0] non_hex_byte();
    logic [7:0] c;
    do begin
      c = 8'($urandom_range(0, 255));
    end while (c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]});
    return c;
  endfunction

  // One end of a range or a lone member: usually the byte itself, sometimes
  // the same code written as a two-digit escape. A literal escape byte
  // always goes through the escape form.
  task automatic send_atom(input logic [7:0] c);
    if (c == CH_ESC || $urandom_range(0, 2) == 0) begin
      send_byte(CH_ESC);
      send_byte(hex_char(c[7:4]));
      send_byte(hex_char(c[3:0]));
    end else begin
      send_byte(c);
    end
  endtask

  // A random spec built from well-formed pieces with random content, mixed
  // with raw noise bytes and, now and then, a truncated escape or range
  // right before the end transaction; now and then the spec is a lone star.
  task automatic send_random_spec();
    int         pieces;
    logic [7:0] lo;
    logic [7:0] hi;
    if ($urandom_range(0, 15) == 0) begin
      send_byte(CH_STAR);
      send_end();
      return;
    end
    pieces = $urandom_range(0, 8);
    repeat (pieces) begin
      case ($urandom_range(0, 5))
        0: send_byte(8'($urandom_range(0, 255)));
        1: send_byte(8'($urandom_range(8'h20, 8'h7f)));
        2: begin
          send_byte(CH_ESC);
          send_byte(hex_char(4'($urandom_range(0, 15))));
          if ($urandom_range(0, 3) == 0) send_byte(8'($urandom_range(0, 255)));
          else send_byte(hex_char(4'($urandom_range(0, 15))));
        end
        3: begin
          send_byte(CH_ESC);
          send_byte(non_hex_byte());
        end
        default: begin
          lo = 8'($urandom_range(0, 255));
          if ($urandom_range(0, 3) == 0) hi = 8'($urandom_range(0, 255));
          else hi = 8'($urandom_range(lo, 255));
          send_atom(lo);
          send_byte(CH_DASH);
          send_atom(hi);
        end
      endcase
    end
    case ($urandom_range(0, 7))
      0: send_byte(CH_ESC);
      1: begin
        send_byte(CH_ESC);
        send_byte(hex_char(4'($urandom_range(0, 15))));
      end
      2: begin
        send_atom(8'($urandom_range(0, 255)));
        send_byte(CH_DASH);
      end
      3: begin
        send_atom(8'($urandom_range(0, 255)));
        send_byte(CH_DASH);
        send_byte(CH_ESC);
      end
      4: begin
        send_atom(8'($urandom_range(0, 255)));
        send_byte(CH_DASH);
        send_byte(CH_ESC);
        send_byte(hex_char(4'($urandom_range(0, 15))));
      end
      default: ;
    endcase
    send_end();
  endtask

  // --------------------------------------------------------------------------
  // Main sequence: reset, a directed set of specs, then random specs with
  // one long receiver hold-off at the start and one full drain midway.
  // --------------------------------------------------------------------------
  initial begin
    bit drained;
    drained      = 1'b0;
    board        = new();
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_kind      = KIND_BYTE;
    in_spec_byte = 8'h00;
    repeat (2) @(negedge clk);
    rst_n = 1'b1;

    // Empty spec gives four zero words.
    send_end();
    // A spec of exactly one star fills the set.
    send_text("*");
    send_end();
    // A lone trailing escape adds code zero.
    send_text("~");
    send_end();
    // A trailing escape with one hex digit adds that digit's value.
    send_text("~A");
    send_end();
    // Hex escape with a non-hex low byte, escaped literal dash, the zero
    // byte as an ordinary member, the top code, and a range from 0x80 up to
    // an escaped 0xff.
    send_text("~4g~-");
    send_byte(8'h00);
    send_byte(8'hff);
    send_byte(8'h80);
    send_text("-~ff");
    send_end();
    // Inverted range adds nothing; a trailing dash after the zero byte is a
    // range down to zero, which adds code zero.
    send_text("z-a");
    send_byte(8'h00);
    send_byte(CH_DASH);
    send_end();

    // Long hold-off on the result side while specs keep coming.
    hold_receiver = 1'b1;
    while (items_sent < TotalItems) begin
      if (!drained && items_sent >= DrainAt) begin
        // Pause the sender until every outstanding word has been checked.
        drained = 1'b1;
        @(negedge clk);
        in_valid = 1'b0;
        while (board.pending() != 0) @(negedge clk);
      end
      if (items_sent >= TailStart) tail_phase = 1'b1;
      send_random_spec();
    end
    tail_phase = 1'b1;
    @(negedge clk);
    in_valid = 1'b0;

    // Let the last set drain, then keep watching for any stray word.
    while (board.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Summary: %0d input transactions, %0d sets closed, %0d words compared",
             items_sent, board.sets_closed, board.words_checked);
    $display("Summary: %0d mismatched or unexpected words", board.errors);
    if (board.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
